>>> hdl/rational_arithmetic_unit_top_assert.svh
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RAU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau check failed");

// next-cycle implication, checked outside reset
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rau check failed");

`endif

>>> hdl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int DEN_W           = 31;
  localparam int REQ_W           = 3;
  localparam int STATUS_W        = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD  = 3'd0,
    REQ_SUB  = 3'd1,
    REQ_MUL  = 3'd2,
    REQ_DIV  = 3'd3,
    REQ_LESS = 3'd4,
    REQ_EQ   = 3'd5,
    REQ_NEG  = 3'd6,
    REQ_RED  = 3'd7
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

endpackage

>>> hdl/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: one request (two fractions and an operation) gives one reduced
// fraction or compare flag. Operands are first brought to lowest terms with a positive
// denominator, the operation is done on exact double-width cross products, and the result is
// reduced again. Each reduction runs a binary gcd by shift and subtract, shifts the common
// power of two back in, then divides numerator and denominator by one bit-serial restoring
// divider, one quotient bit per cycle. A request runs up to three reductions plus the multiply and
// compare steps. Input is stalled while a request is in work; a finished result waits in the
// output register while the next request is taken.
`include "rational_arithmetic_unit_top_assert.svh"

module rational_arithmetic_unit_top
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [FIELD_W-1:0]  a_num,
  input  logic [FIELD_W-1:0]  a_den,
  input  logic [FIELD_W-1:0]  b_num,
  input  logic [FIELD_W-1:0]  b_den,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [FIELD_W-1:0]  res_num,
  output logic [DEN_W-1:0]    res_den,
  output logic                less_flag,
  output logic                equal_flag,
  output logic [STATUS_W-1:0] status
);

  localparam int W  = VALUE_WIDTH;
  localparam int P  = 2 * W;
  localparam int KW = $clog2(P) + 1;
  localparam int CW = $clog2(P);
  localparam logic [P-1:0] LIM = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_RED_START, S_GCD_TWO, S_GCD_LOOP, S_GCD_FIX, S_DIV_X, S_DIV_Y,
    S_RED_END, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_CHECK, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;

  state_t          state;
  phase_t          phase;
  req_t            op;
  logic            a_neg, b_neg, r_neg;
  logic [W-1:0]    a_mag, a_dm, b_mag, b_dm;
  logic [P-1:0]    rx, ry, gu, gv, g, dq, rem, p1, p2, p3;
  logic [KW-1:0]   k;
  logic [CW-1:0]   cnt;
  logic [FIELD_W-1:0]  o_num;
  logic [DEN_W-1:0]    o_den;
  logic            o_lt, o_eq;
  status_t         o_st;

  // magnitude of the low W bits, sign at bit W-1
  function automatic logic [W-1:0] mag_of(input logic [FIELD_W-1:0] v);
    logic [W-1:0] m;
    m = v[W-1:0];
    return m[W-1] ? (~m + 1'b1) : m;
  endfunction

  // raw operand magnitudes and the input error check
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         unary_req, in_err;
  req_t         req_in;
  assign req_in    = req_t'(req_type);
  assign an_m      = mag_of(a_num);
  assign ad_m      = mag_of(a_den);
  assign bn_m      = mag_of(b_num);
  assign bd_m      = mag_of(b_den);
  assign unary_req = (req_in == REQ_NEG) || (req_in == REQ_RED);
  assign in_err    = (ad_m == '0) || (!unary_req && (bd_m == '0)) ||
                     ((req_in == REQ_DIV) && (bn_m == '0));

  // shared multiplier operand selection
  logic [W-1:0] mx, my;
  logic [P-1:0] prod;
  always_comb begin
    mx = a_mag;
    my = b_dm;
    unique case (state)
      S_MUL1: begin
        mx = a_mag;
        my = (op == REQ_MUL) ? b_mag : b_dm;
      end
      S_MUL2: begin
        mx = b_mag;
        my = a_dm;
      end
      default: begin
        mx = a_dm;
        my = (op == REQ_DIV) ? b_mag : b_dm;
      end
    endcase
  end
  assign prod = {{W{1'b0}}, mx} * {{W{1'b0}}, my};

  // restoring divider step
  logic [P:0]   rem_sh;
  logic         div_ge;
  logic [P-1:0] rem_nx, dq_nx;
  assign rem_sh = {rem, dq[P-1]};
  assign div_ge = rem_sh >= {1'b0, g};
  assign rem_nx = div_ge ? P'(rem_sh - {1'b0, g}) : rem_sh[P-1:0];
  assign dq_nx  = {dq[P-2:0], div_ge};

  // signs after the current reduction
  logic         rx_zero, an_new, bn_eff;
  logic [W-1:0] rv;
  assign rx_zero = (rx == '0);
  assign an_new  = a_neg && !rx_zero;
  assign bn_eff  = ((op == REQ_SUB) && (b_mag != '0)) ? !b_neg : b_neg;
  assign rv      = r_neg ? (~rx[W-1:0] + 1'b1) : rx[W-1:0];

  assign in_stall = (state != S_IDLE);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register empties on a taken transaction
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= req_in;
            a_neg <= a_num[W-1] ^ a_den[W-1];
            b_neg <= b_num[W-1] ^ b_den[W-1];
            a_mag <= an_m;
            a_dm  <= ad_m;
            b_mag <= bn_m;
            b_dm  <= bd_m;
            o_num <= '0;
            o_den <= DEN_W'(1);
            o_lt  <= 1'b0;
            o_eq  <= 1'b0;
            rx    <= {{W{1'b0}}, an_m};
            ry    <= {{W{1'b0}}, ad_m};
            phase <= PH_A;
            if (in_err) begin
              o_st  <= STATUS_ZERO_DEN;
              state <= S_DONE;
            end else begin
              o_st  <= STATUS_OK;
              state <= S_RED_START;
            end
          end
        end
        S_RED_START: begin
          if (rx_zero) begin
            ry    <= P'(1);
            state <= S_RED_END;
          end else begin
            gu    <= rx;
            gv    <= ry;
            k     <= '0;
            state <= S_GCD_TWO;
          end
        end
        // strip the common power of two
        S_GCD_TWO: begin
          if (!gu[0] && !gv[0]) begin
            gu <= gu >> 1;
            gv <= gv >> 1;
            k  <= k + 1'b1;
          end else begin
            state <= S_GCD_LOOP;
          end
        end
        // odd part of the gcd by shift and subtract
        S_GCD_LOOP: begin
          if (gu == '0) begin
            g     <= gv;
            state <= S_GCD_FIX;
          end else if (gv == '0) begin
            g     <= gu;
            state <= S_GCD_FIX;
          end else if (!gu[0]) begin
            gu <= gu >> 1;
          end else if (!gv[0]) begin
            gv <= gv >> 1;
          end else if (gu >= gv) begin
            gu <= gu - gv;
          end else begin
            gv <= gv - gu;
          end
        end
        S_GCD_FIX: begin
          if (k == '0) begin
            dq    <= rx;
            rem   <= '0;
            cnt   <= CW'(P - 1);
            state <= S_DIV_X;
          end else begin
            g <= g << 1;
            k <= k - 1'b1;
          end
        end
        S_DIV_X: begin
          if (cnt == '0) begin
            rx    <= dq_nx;
            dq    <= ry;
            rem   <= '0;
            cnt   <= CW'(P - 1);
            state <= S_DIV_Y;
          end else begin
            rem <= rem_nx;
            dq  <= dq_nx;
            cnt <= cnt - 1'b1;
          end
        end
        S_DIV_Y: begin
          rem <= rem_nx;
          dq  <= dq_nx;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            ry    <= dq_nx;
            state <= S_RED_END;
          end
        end
        S_RED_END: begin
          unique case (phase)
            PH_A: begin
              a_mag <= rx[W-1:0];
              a_dm  <= ry[W-1:0];
              a_neg <= an_new;
              if ((op == REQ_NEG) || (op == REQ_RED)) begin
                r_neg <= ((op == REQ_NEG) && !rx_zero) ? !an_new : an_new;
                phase <= PH_R;
                state <= S_RED_START;
              end else begin
                rx    <= {{W{1'b0}}, b_mag};
                ry    <= {{W{1'b0}}, b_dm};
                phase <= PH_B;
                state <= S_RED_START;
              end
            end
            PH_B: begin
              b_mag <= rx[W-1:0];
              b_dm  <= ry[W-1:0];
              b_neg <= b_neg && !rx_zero;
              if ((op == REQ_DIV) && rx_zero) begin
                o_st  <= STATUS_ZERO_DEN;
                state <= S_DONE;
              end else if (op == REQ_EQ) begin
                o_eq  <= (a_neg == (b_neg && !rx_zero)) && (a_mag == rx[W-1:0]) &&
                         (a_dm == ry[W-1:0]);
                state <= S_DONE;
              end else begin
                state <= S_MUL1;
              end
            end
            default: begin
              r_neg <= r_neg && !rx_zero;
              state <= S_CHECK;
            end
          endcase
        end
        S_MUL1: begin
          p1    <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= prod;
          state <= S_MUL3;
        end
        S_MUL3: begin
          p3    <= prod;
          state <= S_COMB;
        end
        // combine cross products
        S_COMB: begin
          phase <= PH_R;
          ry    <= p3;
          case (op) inside
            REQ_ADD, REQ_SUB: begin
              state <= S_RED_START;
              if (a_neg == bn_eff) begin
                rx    <= p1 + p2;
                r_neg <= a_neg;
              end else if (p1 >= p2) begin
                rx    <= p1 - p2;
                r_neg <= a_neg;
              end else begin
                rx    <= p2 - p1;
                r_neg <= bn_eff;
              end
            end
            REQ_MUL, REQ_DIV: begin
              state <= S_RED_START;
              rx    <= p1;
              r_neg <= a_neg ^ b_neg;
            end
            default: begin
              o_lt  <= (a_neg && !b_neg) || (a_neg && b_neg && (p1 > p2)) ||
                       (!a_neg && !b_neg && (p1 < p2));
              state <= S_DONE;
            end
          endcase
        end
        S_CHECK: begin
          if ((rx > LIM) || (ry > LIM)) begin
            o_st <= STATUS_OVERFLOW;
          end else begin
            o_num <= FIELD_W'(signed'(rv));
            o_den <= DEN_W'(ry);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            res_num    <= o_num;
            res_den    <= o_den;
            less_flag  <= o_lt;
            equal_flag <= o_eq;
            status     <= o_st;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // error and overflow results carry a neutral fraction
  `RAU_ASSERT_IMP(a_err_neutral, out_valid && (status != STATUS_OK), (res_num == '0) && (res_den == DEN_W'(1)) && !less_flag && !equal_flag)
  `RAU_ASSERT_IMP(a_den_nonzero, out_valid, res_den != '0)
  `RAU_ASSERT_IMP(a_flags_excl, out_valid, !(less_flag && equal_flag))
  `RAU_ASSERT_IMP(a_gcd_live, state == S_GCD_LOOP, (gu != '0) || (gv != '0))
  `RAU_ASSERT_NEXT(a_take_busy, in_valid && !in_stall, state != S_IDLE)

endmodule
